// ===== hw/rtl/dpmmu_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface types for the paging MMU.
package dpmmu_pkg;

   localparam int VA_W         = 32;
   localparam int PA_W         = 20;
   localparam int CMD_W        = 2;
   localparam int SHIFT_W      = 5;
   localparam int PAGES_CFG_W  = 7;
   localparam int FRAMES_CFG_W = 5;
   localparam int CSR_DATA_W   = 7;
   localparam int CSR_IDX_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGES_IN_USE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 2'd2;

   localparam logic [SHIFT_W-1:0]      RST_PAGE_SHIFT    = 5'd8;
   localparam logic [PAGES_CFG_W-1:0]  RST_PAGES_IN_USE  = 7'd64;
   localparam logic [FRAMES_CFG_W-1:0] RST_FRAMES_IN_USE = 5'd16;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;

   typedef struct packed {
      logic clear;
      logic capture;
      logic hit;
      logic alloc;
      logic scan_init;
      logic scan_step;
      logic victim_sel;
      logic victim_take;
      logic commit;
      logic result_load;
   } dpmmu_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic illegal;
      logic present;
      logic free_avail;
      logic scan_last;
      logic out_free;
   } dpmmu_status_type;

endpackage

// ===== hw/rtl/dpmmu_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, page map, frame tables, LRU scan and result register.
module dpmmu_datapath #(
   parameter int MAX_PAGES  = 64,
   parameter int MAX_FRAMES = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [dpmmu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dpmmu_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic [dpmmu_pkg::VA_W-1:0]             req_virtual_address,
   input  logic [dpmmu_pkg::CMD_W-1:0]            req_command,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [dpmmu_pkg::PA_W-1:0]             rsp_physical_address,
   output logic                                   rsp_illegal,
   output logic                                   rsp_page_fault,
   output logic                                   rsp_evicted,
   output logic [$clog2(MAX_PAGES)-1:0]           rsp_victim_page,
   output logic                                   rsp_victim_writeback,
   output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] rsp_frame_used,
   input  dpmmu_pkg::dpmmu_cmd_type               cmd,
   output dpmmu_pkg::dpmmu_status_type            status
);

   localparam int PAGE_W  = $clog2(MAX_PAGES);
   localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FCNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int VA_W    = dpmmu_pkg::VA_W;
   localparam int PA_W    = dpmmu_pkg::PA_W;

   typedef struct packed {
      logic               present;
      logic [FRAME_W-1:0] frame;
   } map_entry_type;

   // configuration
   logic [dpmmu_pkg::SHIFT_W-1:0]      shift_ff;
   logic [dpmmu_pkg::PAGES_CFG_W-1:0]  pages_ff;
   logic [dpmmu_pkg::FRAMES_CFG_W-1:0] frames_ff;

   // current word
   logic [VA_W-1:0]               va_ff;
   logic [dpmmu_pkg::CMD_W-1:0]   op_ff;
   logic [FRAME_W-1:0]            frame_ff;
   logic                          fault_ff;
   logic                          evicted_ff;
   logic [PAGE_W-1:0]             victim_ff;
   logic                          wb_ff;

   // page map
   map_entry_type                 map_mem [MAX_PAGES];
   map_entry_type                 map_rd_ff;
   logic                          map_we;
   logic [PAGE_W-1:0]             map_waddr;
   map_entry_type                 map_wdata;
   logic [PAGE_W-1:0]             clr_idx_ff;

   // frame tables
   logic [PAGE_W-1:0]             owner_mem [MAX_FRAMES];
   logic [STAMP_BITS-1:0]         stamp_mem [MAX_FRAMES];
   logic                          dirty_mem [MAX_FRAMES];
   logic [PAGE_W-1:0]             owner_rd_ff;
   logic                          dirty_rd_ff;
   logic [STAMP_BITS-1:0]         stamp_rd_ff;

   logic [FCNT_W-1:0]             next_free_ff;
   logic [STAMP_BITS-1:0]         clock_ff;

   // LRU scan
   logic [FRAME_W-1:0]            rd_idx_ff;
   logic [FRAME_W-1:0]            cmp_idx_ff;
   logic                          cmp_valid_ff;
   logic [FRAME_W-1:0]            best_ff;
   logic [STAMP_BITS-1:0]         best_stamp_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [PA_W-1:0]               rsp_pa_ff;
   logic                          rsp_illegal_ff;
   logic                          rsp_fault_ff;
   logic                          rsp_evicted_ff;
   logic [PAGE_W-1:0]             rsp_victim_ff;
   logic                          rsp_wb_ff;
   logic [FRAME_W-1:0]            rsp_frame_ff;

   logic [VA_W-1:0]               page_num;
   logic [VA_W-1:0]               offset;
   logic [PAGE_W-1:0]             page_idx;
   logic [VA_W-1:0]               eff_pages;
   logic [FCNT_W-1:0]             eff_frames;
   logic [VA_W-1:0]               pa_sum;
   logic                          is_write;

   assign page_num = va_ff >> shift_ff;
   assign offset   = va_ff & ~({VA_W{1'b1}} << shift_ff);
   assign page_idx = page_num[PAGE_W-1:0];
   assign pa_sum   = (VA_W'(frame_ff) << shift_ff) + offset;
   assign is_write = (op_ff == dpmmu_pkg::CMD_WRITE);

   always_comb begin
      if (32'(pages_ff) > 32'(MAX_PAGES)) begin
         eff_pages = 32'(MAX_PAGES);
      end else begin
         eff_pages = 32'(pages_ff);
      end
      if (frames_ff == '0) begin
         eff_frames = FCNT_W'(1);
      end else if (32'(frames_ff) > 32'(MAX_FRAMES)) begin
         eff_frames = FCNT_W'(MAX_FRAMES);
      end else begin
         eff_frames = FCNT_W'(frames_ff);
      end
   end

   always_comb begin
      status.clear_last = (clr_idx_ff == PAGE_W'(MAX_PAGES - 1));
      status.illegal    = (page_num >= eff_pages);
      status.present    = map_rd_ff.present;
      status.free_avail = (next_free_ff < eff_frames);
      status.scan_last  = (FCNT_W'(rd_idx_ff) == eff_frames - FCNT_W'(1));
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // page map write port
   always_comb begin
      map_we    = 1'b0;
      map_waddr = page_idx;
      map_wdata = '0;
      if (cmd.clear) begin
         map_we    = 1'b1;
         map_waddr = clr_idx_ff;
      end else if (cmd.victim_take) begin
         map_we    = 1'b1;
         map_waddr = owner_rd_ff;
      end else if (cmd.commit && fault_ff) begin
         map_we            = 1'b1;
         map_wdata.present = 1'b1;
         map_wdata.frame   = frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[page_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         stamp_mem[frame_ff] <= clock_ff;
         if (fault_ff) begin
            owner_mem[frame_ff] <= page_idx;
         end
         if (fault_ff || is_write) begin
            dirty_mem[frame_ff] <= is_write;
         end
      end
      stamp_rd_ff <= stamp_mem[rd_idx_ff];
      owner_rd_ff <= owner_mem[best_ff];
      dirty_rd_ff <= dirty_mem[best_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= dpmmu_pkg::RST_PAGE_SHIFT;
         pages_ff     <= dpmmu_pkg::RST_PAGES_IN_USE;
         frames_ff    <= dpmmu_pkg::RST_FRAMES_IN_USE;
         clr_idx_ff   <= '0;
         next_free_ff <= '0;
         clock_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               dpmmu_pkg::CSR_PAGE_SHIFT: begin
                  shift_ff <= csr_write_data[dpmmu_pkg::SHIFT_W-1:0];
               end
               dpmmu_pkg::CSR_PAGES_IN_USE: begin
                  pages_ff <= csr_write_data[dpmmu_pkg::PAGES_CFG_W-1:0];
               end
               dpmmu_pkg::CSR_FRAMES_IN_USE: begin
                  frames_ff <= csr_write_data[dpmmu_pkg::FRAMES_CFG_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (cmd.clear) begin
            clr_idx_ff <= clr_idx_ff + PAGE_W'(1);
         end
         if (cmd.alloc) begin
            next_free_ff <= next_free_ff + FCNT_W'(1);
         end
         if (cmd.commit) begin
            clock_ff <= clock_ff + STAMP_BITS'(1);
         end
         cmp_valid_ff <= cmd.scan_step;
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         va_ff      <= req_virtual_address;
         op_ff      <= req_command;
         fault_ff   <= 1'b0;
         evicted_ff <= 1'b0;
         victim_ff  <= '0;
         wb_ff      <= 1'b0;
      end
      if (cmd.hit) begin
         frame_ff <= map_rd_ff.frame;
      end
      if (cmd.alloc) begin
         frame_ff <= FRAME_W'(next_free_ff);
         fault_ff <= 1'b1;
      end
      if (cmd.scan_init) begin
         rd_idx_ff <= '0;
         fault_ff  <= 1'b1;
      end
      if (cmd.scan_step) begin
         rd_idx_ff  <= rd_idx_ff + FRAME_W'(1);
         cmp_idx_ff <= rd_idx_ff;
      end
      // strict compare keeps the lowest frame on equal stamps
      if (cmp_valid_ff && (cmp_idx_ff == '0 || best_stamp_ff > stamp_rd_ff)) begin
         best_ff       <= cmp_idx_ff;
         best_stamp_ff <= stamp_rd_ff;
      end
      if (cmd.victim_sel) begin
         frame_ff <= best_ff;
      end
      if (cmd.victim_take) begin
         evicted_ff <= 1'b1;
         victim_ff  <= owner_rd_ff;
         wb_ff      <= dirty_rd_ff;
      end
      if (cmd.result_load) begin
         if (status.illegal) begin
            rsp_pa_ff      <= '0;
            rsp_illegal_ff <= 1'b1;
            rsp_fault_ff   <= 1'b0;
            rsp_evicted_ff <= 1'b0;
            rsp_victim_ff  <= '0;
            rsp_wb_ff      <= 1'b0;
            rsp_frame_ff   <= '0;
         end else begin
            rsp_pa_ff      <= pa_sum[PA_W-1:0];
            rsp_illegal_ff <= 1'b0;
            rsp_fault_ff   <= fault_ff;
            rsp_evicted_ff <= evicted_ff;
            rsp_victim_ff  <= victim_ff;
            rsp_wb_ff      <= wb_ff;
            rsp_frame_ff   <= frame_ff;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_pa_ff;
   assign rsp_illegal          = rsp_illegal_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_evicted          = rsp_evicted_ff;
   assign rsp_victim_page      = rsp_victim_ff;
   assign rsp_victim_writeback = rsp_wb_ff;
   assign rsp_frame_used       = rsp_frame_ff;

   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FCNT_W'(MAX_FRAMES))
      else $error("free frame counter beyond frame count");

   a_clock_only_on_commit: assert property (@(posedge clock)
      (!reset && !cmd.commit) |=> (reset || clock_ff == $past(clock_ff)))
      else $error("access clock moved without a commit");

   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.victim_take |-> (next_free_ff >= eff_frames))
      else $error("eviction while a free frame remains");

endmodule

// ===== hw/rtl/dpmmu_control.sv =====
`timescale 1ns / 1ps
// Controller state machine sequencing lookup, allocation, LRU scan and commit.
module dpmmu_control (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  dpmmu_pkg::dpmmu_status_type status,
   output dpmmu_pkg::dpmmu_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_VICTIM_RD,
      ST_VICTIM,
      ST_COMMIT,
      ST_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.illegal) begin
               state_in = ST_RESULT;
            end else if (status.present) begin
               cmd.hit  = 1'b1;
               state_in = ST_COMMIT;
            end else if (status.free_avail) begin
               cmd.alloc = 1'b1;
               state_in  = ST_COMMIT;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_SCAN_LAST;
            end
         end
         ST_SCAN_LAST: begin
            state_in = ST_VICTIM_RD;
         end
         ST_VICTIM_RD: begin
            cmd.victim_sel = 1'b1;
            state_in       = ST_VICTIM;
         end
         ST_VICTIM: begin
            cmd.victim_take = 1'b1;
            state_in        = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_at_a_time: assert property (@(posedge clock)
      (!reset && req_valid && req_ready) |=> (reset || !req_ready))
      else $error("second word taken while one is in flight");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> status.out_free)
      else $error("result register overwritten");

   a_scan_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> (!status.present && !status.illegal))
      else $error("LRU scan on a resident or illegal page");

endmodule

// ===== hw/rtl/demand_paging_mmu_lru_unit.sv =====
`timescale 1ns / 1ps
// Demand-paging MMU with LRU replacement: top level.
//
// One access word is handled at a time; the next is taken as soon as the
// current result sits in the output register. A miss with all frames in
// use runs an LRU scan over the effective frame count, which reads one
// frame stamp per cycle from the frame stamp memory. After reset the page
// map is cleared entry by entry, while no access word is taken; register
// writes are accepted throughout.
module demand_paging_mmu_lru_unit #(
   parameter int MAX_PAGES  = 64,
   parameter int MAX_FRAMES = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [dpmmu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dpmmu_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [dpmmu_pkg::VA_W-1:0]             req_virtual_address,
   input  logic [dpmmu_pkg::CMD_W-1:0]            req_command,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [dpmmu_pkg::PA_W-1:0]             rsp_physical_address,
   output logic                                   rsp_illegal,
   output logic                                   rsp_page_fault,
   output logic                                   rsp_evicted,
   output logic [$clog2(MAX_PAGES)-1:0]           rsp_victim_page,
   output logic                                   rsp_victim_writeback,
   output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] rsp_frame_used
);

   dpmmu_pkg::dpmmu_cmd_type    cmd;
   dpmmu_pkg::dpmmu_status_type status;

   dpmmu_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dpmmu_datapath #(
      .MAX_PAGES  (MAX_PAGES),
      .MAX_FRAMES (MAX_FRAMES),
      .STAMP_BITS (STAMP_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_virtual_address  (req_virtual_address),
      .req_command          (req_command),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_physical_address (rsp_physical_address),
      .rsp_illegal          (rsp_illegal),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_evicted          (rsp_evicted),
      .rsp_victim_page      (rsp_victim_page),
      .rsp_victim_writeback (rsp_victim_writeback),
      .rsp_frame_used       (rsp_frame_used),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule
